// ===== sv/sfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the bytewise CRC-16 step for the seven-bit frame receiver.
// Used by sfr_deframe, sfr_result and the top level; depends on nothing.
package sfr_pkg;

    localparam logic [3:0]  POS_FIRST    = 4'd0;
    localparam logic [3:0]  POS_LAST     = 4'd11;
    localparam logic [3:0]  POS_IDLE     = 4'd15;
    localparam logic [3:0]  DATA_LEN     = 4'd12;
    localparam logic [3:0]  RAW_CRC_LEN  = 4'd8;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_FLAG_ERR = 2'd2
    } status_t;

    // Summary of one completed frame, handed from the deframer to the result stage
    typedef struct packed {
        logic        crc_ok;
        logic        flags_bad;
        logic        flag;
        logic [63:0] pwm;
    } frame_t;

    // CRC-16, MSB first, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int j = 0; j < 8; j++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/sfr_deframe.sv =====
`timescale 1ns / 1ps
// Frame tracking, incremental 7-to-8 bit unpacking and running CRC, one beat a cycle while byte_go is high.
// Depends on sfr_pkg.
module sfr_deframe (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_go,
    input  logic [7:0]      byte_data,
    output logic            frame_last,
    output sfr_pkg::frame_t frame
);
    import sfr_pkg::*;

    logic [3:0]  pos_reg, pos_next;
    logic [2:0]  nbits_reg, nbits_next;
    logic [3:0]  raw_cnt_reg, raw_cnt_next;
    logic [7:0]  start_reg, start_next;
    logic [6:0]  acc_reg, acc_next;
    logic [15:0] crc_reg, crc_next;
    logic [63:0] shadow_reg, shadow_next;
    logic [7:0]  rxhi_reg, rxhi_next;

    logic        is_start;
    logic        in_frame;
    logic        emit;
    logic [2:0]  shift_amt;
    logic [13:0] combined;
    logic [13:0] shifted;
    logic [7:0]  raw;
    logic [6:0]  acc_mask;

    always_comb
    begin
        is_start   = byte_data[7];
        in_frame   = pos_reg < DATA_LEN;
        frame_last = !is_start && (pos_reg == POS_LAST);
        combined   = {acc_reg, byte_data[6:0]};
        emit       = (nbits_reg != 3'd0);
        shift_amt  = nbits_reg - 3'd1;
        shifted    = combined >> shift_amt;
        raw        = shifted[7:0];
        acc_mask   = (7'd1 << shift_amt) - 7'd1;

        frame.crc_ok    = (crc_reg == {rxhi_reg, raw});
        frame.flags_bad = (start_reg[6:1] != 6'd0);
        frame.flag      = start_reg[0];
        frame.pwm       = shadow_reg;

        pos_next     = pos_reg;
        nbits_next   = nbits_reg;
        raw_cnt_next = raw_cnt_reg;
        start_next   = start_reg;
        acc_next     = acc_reg;
        crc_next     = crc_reg;
        shadow_next  = shadow_reg;
        rxhi_next    = rxhi_reg;

        if (byte_go)
        begin
            if (is_start)
            begin
                // a start byte always opens a fresh frame
                start_next   = byte_data;
                pos_next     = POS_FIRST;
                nbits_next   = 3'd0;
                acc_next     = 7'd0;
                raw_cnt_next = 4'd0;
                crc_next     = crc_byte(CRC_INIT, byte_data);
            end
            else if (in_frame)
            begin
                pos_next = frame_last ? POS_IDLE : pos_reg + 4'd1;
                if (emit)
                begin
                    nbits_next   = shift_amt;
                    acc_next     = combined[6:0] & acc_mask;
                    raw_cnt_next = raw_cnt_reg + 4'd1;
                    if (raw_cnt_reg < RAW_CRC_LEN)
                    begin
                        crc_next    = crc_byte(crc_reg, raw);
                        shadow_next = {shadow_reg[55:0], raw};
                    end
                    else if (raw_cnt_reg == RAW_CRC_LEN)
                    begin
                        rxhi_next = raw;
                    end
                end
                else
                begin
                    nbits_next = 3'd7;
                    acc_next   = byte_data[6:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_IDLE;
            nbits_reg   <= 3'd0;
            raw_cnt_reg <= 4'd0;
            start_reg   <= 8'd0;
        end
        else
        begin
            pos_reg     <= pos_next;
            nbits_reg   <= nbits_next;
            raw_cnt_reg <= raw_cnt_next;
            start_reg   <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        crc_reg    <= crc_next;
        shadow_reg <= shadow_next;
        rxhi_reg   <= rxhi_next;
    end

endmodule

// ===== sv/sfr_result.sv =====
`timescale 1ns / 1ps
// Frame verdict, PWM and flag latches, outcome counters and the result register.
// Depends on sfr_pkg.
module sfr_result (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            frame_go,
    input  sfr_pkg::frame_t frame,
    input  logic            frame_stall,
    output logic            frame_valid,
    output logic [1:0]      status,
    output logic [15:0]     pwm_0,
    output logic [15:0]     pwm_1,
    output logic [15:0]     pwm_2,
    output logic [15:0]     pwm_3,
    output logic            frame_flags,
    output logic            have_frame,
    output logic [31:0]     good_count,
    output logic [31:0]     crc_error_count,
    output logic [31:0]     flag_error_count
);
    import sfr_pkg::*;

    logic        valid_reg, valid_next;
    status_t     status_reg, status_next;
    logic [15:0] pwm0_reg, pwm0_next;
    logic [15:0] pwm1_reg, pwm1_next;
    logic [15:0] pwm2_reg, pwm2_next;
    logic [15:0] pwm3_reg, pwm3_next;
    logic        flags_reg, flags_next;
    logic        seen_reg, seen_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] crc_err_reg, crc_err_next;
    logic [31:0] flag_err_reg, flag_err_next;

    always_comb
    begin
        valid_next    = valid_reg && frame_stall;
        status_next   = status_reg;
        pwm0_next     = pwm0_reg;
        pwm1_next     = pwm1_reg;
        pwm2_next     = pwm2_reg;
        pwm3_next     = pwm3_reg;
        flags_next    = flags_reg;
        seen_next     = seen_reg;
        good_next     = good_reg;
        crc_err_next  = crc_err_reg;
        flag_err_next = flag_err_reg;

        if (frame_go)
        begin
            valid_next = 1'b1;
            // CRC is judged before the flags; a rejected frame keeps the latches
            if (!frame.crc_ok)
            begin
                status_next  = ST_CRC_ERR;
                crc_err_next = crc_err_reg + 32'd1;
            end
            else if (frame.flags_bad)
            begin
                status_next   = ST_FLAG_ERR;
                flag_err_next = flag_err_reg + 32'd1;
            end
            else
            begin
                status_next = ST_GOOD;
                pwm0_next   = frame.pwm[63:48];
                pwm1_next   = frame.pwm[47:32];
                pwm2_next   = frame.pwm[31:16];
                pwm3_next   = frame.pwm[15:0];
                flags_next  = frame.flag;
                seen_next   = 1'b1;
                good_next   = good_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            status_reg   <= ST_GOOD;
            pwm0_reg     <= 16'd0;
            pwm1_reg     <= 16'd0;
            pwm2_reg     <= 16'd0;
            pwm3_reg     <= 16'd0;
            flags_reg    <= 1'b0;
            seen_reg     <= 1'b0;
            good_reg     <= 32'd0;
            crc_err_reg  <= 32'd0;
            flag_err_reg <= 32'd0;
        end
        else
        begin
            valid_reg    <= valid_next;
            status_reg   <= status_next;
            pwm0_reg     <= pwm0_next;
            pwm1_reg     <= pwm1_next;
            pwm2_reg     <= pwm2_next;
            pwm3_reg     <= pwm3_next;
            flags_reg    <= flags_next;
            seen_reg     <= seen_next;
            good_reg     <= good_next;
            crc_err_reg  <= crc_err_next;
            flag_err_reg <= flag_err_next;
        end
    end

    assign frame_valid      = valid_reg;
    assign status           = status_reg;
    assign pwm_0            = pwm0_reg;
    assign pwm_1            = pwm1_reg;
    assign pwm_2            = pwm2_reg;
    assign pwm_3            = pwm3_reg;
    assign frame_flags      = flags_reg;
    assign have_frame       = seen_reg;
    assign good_count       = good_reg;
    assign crc_error_count  = crc_err_reg;
    assign flag_error_count = flag_err_reg;

endmodule

// ===== sv/seven_bit_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// Top level of the seven-bit frame receiver: input register, deframer and result stage.
// Depends on sfr_pkg, sfr_deframe and sfr_result.
//
// Input channel: one received byte per beat on rx_byte (byte_valid / byte_stall).
// A byte with bit 7 set opens a frame; twelve 7-bit data bytes follow. Bytes
// outside a frame are dropped without a result.
// Output channel: one result beat per completed frame (frame_valid / frame_stall)
// carrying the outcome, the latched PWM words and flags, and the three counters.
// The result of a frame's last byte is registered twice: the edge that accepts
// that byte loads the input register, and the edge on which the byte goes on to
// the deframer loads the result register.
// Throughput: one byte per cycle while byte_stall is low; the deframer unpacks one
// byte in each cycle that go is high, and the CRC advances by at most one byte.
// While a result is held by frame_stall, data bytes keep flowing; only the last
// byte of the next frame waits in the input register, and byte_stall rises.
// Reset clears the latches and counters, closes any open frame and empties both
// registers; no clearing pass is needed.
module seven_bit_frame_receiver_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  rx_byte,
    output logic        frame_valid,
    input  logic        frame_stall,
    output logic [1:0]  status,
    output logic [15:0] pwm_0,
    output logic [15:0] pwm_1,
    output logic [15:0] pwm_2,
    output logic [15:0] pwm_3,
    output logic        frame_flags,
    output logic        have_frame,
    output logic [31:0] good_count,
    output logic [31:0] crc_error_count,
    output logic [31:0] flag_error_count
);
    import sfr_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       accept;
    logic       go;
    logic       frame_last;
    logic       frame_go;
    frame_t     frame;

    // hold the last byte of a frame only while the previous result is still waiting
    assign go         = in_valid_reg && (!frame_last || !frame_valid || !frame_stall);
    assign frame_go   = go && frame_last;
    assign byte_stall = in_valid_reg && !go;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    sfr_deframe u_deframe (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_go    (go),
        .byte_data  (in_byte_reg),
        .frame_last (frame_last),
        .frame      (frame)
    );

    sfr_result u_result (
        .clk              (clk),
        .rst_n            (rst_n),
        .frame_go         (frame_go),
        .frame            (frame),
        .frame_stall      (frame_stall),
        .frame_valid      (frame_valid),
        .status           (status),
        .pwm_0            (pwm_0),
        .pwm_1            (pwm_1),
        .pwm_2            (pwm_2),
        .pwm_3            (pwm_3),
        .frame_flags      (frame_flags),
        .have_frame       (have_frame),
        .good_count       (good_count),
        .crc_error_count  (crc_error_count),
        .flag_error_count (flag_error_count)
    );

`ifndef SYNTH
    a_stall_only_on_waiting_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> frame_valid)
        else $error("input stalled without a pending result");

    a_good_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && status == ST_GOOD) |-> have_frame)
        else $error("good result without a latched frame");

    a_good_count_moves_on_good: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(good_count) |-> (frame_valid && status == ST_GOOD))
        else $error("good counter changed without a good result");

    a_crc_count_moves_on_crc_err: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(crc_error_count) |-> (frame_valid && status == ST_CRC_ERR && $stable(pwm_0)))
        else $error("CRC error counter or latch changed unexpectedly");
`endif

endmodule
